[hdl/assert_macros.svh]
// Assertion macros shared by the deinterlacer RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check on every rising clock edge, suspended while reset is asserted
`define MELA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mela assertion failed");
// check on every rising clock edge, reset included
`define MELA_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("mela assertion failed");
`else
`define MELA_ASSERT(label, clk, rst_n, prop)
`define MELA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hdl/mela_pkg.sv]
// Types, register map and byte helpers of the motion adaptive ELA deinterlacer.
// No dependencies; used by mela_lane, mela_merge and the top level.
`default_nettype none
package mela_pkg;

	localparam int unsigned APB_AW = 3;

	// register map, decoded on word address bit only
	localparam logic [0:0] REG_MOTION_THR = 1'b0;
	localparam logic [0:0] REG_VPASS_THR  = 1'b1;

	localparam logic [7:0] MOTION_THR_RST = 8'd15;
	localparam logic [7:0] VPASS_THR_RST  = 8'd15;

	localparam int unsigned NUM_LANES = 4;

	typedef struct packed {
		logic [31:0] row_above;
		logic [31:0] row_below;
		logic [15:0] above_left;
		logic [15:0] above_right;
		logic [15:0] below_left;
		logic [15:0] below_right;
		logic [31:0] prev_opposite;
		logic [31:0] next_opposite;
		logic [31:0] prev_same_above;
		logic [31:0] prev_same_below;
		logic        edge_column;
	} pix_t;

	typedef struct packed {
		logic [31:0] copied_line;
		logic [31:0] new_line;
	} res_t;

	// one byte lane's neighbourhood
	typedef struct packed {
		logic [7:0] va;
		logic [7:0] vb;
		logic [7:0] vc;
		logic [7:0] vd;
		logic [7:0] ve;
		logic [7:0] vf;
		logic [7:0] prv;
		logic [7:0] nxt;
		logic [7:0] psa;
		logic [7:0] psb;
	} lane_in_t;

	// what one lane found
	typedef struct packed {
		logic [7:0] bob;
		logic [7:0] weave;
		logic       tm;
		logic       cm;
		logic       bm;
	} lane_out_t;

	function automatic logic [7:0] avg8(input logic [7:0] x, input logic [7:0] y);
		logic [8:0] s;
		s = {1'b0, x} + {1'b0, y} + 9'd1;
		return s[8:1];
	endfunction

	function automatic logic [7:0] adiff8(input logic [7:0] x, input logic [7:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

endpackage
`default_nettype wire

[hdl/mela_lane.sv]
// One byte lane: edge-based line average, weave average and motion flags.
// Depends on mela_pkg.
`default_nettype none
module mela_lane (
	input  wire mela_pkg::lane_in_t  din,
	input  wire                      chroma,
	input  wire                      edge_column,
	input  wire logic [7:0]          motion_thr,
	input  wire logic [7:0]          vpass_thr,
	output mela_pkg::lane_out_t      dout
);

	logic [7:0] avg_be, diff_be, sc_cd, sc_af, best, diag;
	logic       use_af, vert;

	always_comb begin
		avg_be  = mela_pkg::avg8(din.vb, din.ve);
		diff_be = mela_pkg::adiff8(din.vb, din.ve);
		sc_cd   = mela_pkg::avg8(mela_pkg::adiff8(din.vb, din.vd),
			mela_pkg::adiff8(din.vc, din.ve));
		sc_af   = mela_pkg::avg8(mela_pkg::adiff8(din.va, din.ve),
			mela_pkg::adiff8(din.vb, din.vf));
		use_af  = (sc_af <= sc_cd);
		best    = use_af ? mela_pkg::adiff8(din.va, din.vf) : mela_pkg::adiff8(din.vc, din.vd);
		diag    = use_af ? mela_pkg::avg8(din.va, din.vf) : mela_pkg::avg8(din.vc, din.vd);
		vert    = chroma || edge_column || (diff_be <= best) || (diff_be <= vpass_thr);

		dout.bob   = vert ? avg_be : diag;
		dout.weave = mela_pkg::avg8(din.prv, din.nxt);
		// motion only counts on luma lanes
		dout.tm = !chroma && (mela_pkg::adiff8(din.vb, din.psa) > motion_thr);
		dout.cm = !chroma && (mela_pkg::adiff8(din.prv, din.nxt) > motion_thr);
		dout.bm = !chroma && (mela_pkg::adiff8(din.ve, din.psb) > motion_thr);
	end

endmodule
`default_nettype wire

[hdl/mela_merge.sv]
// Merging stage: combines lane motion flags and picks bob or weave per byte.
// Depends on mela_pkg.
`default_nettype none
module mela_merge (
	input  wire mela_pkg::lane_out_t [mela_pkg::NUM_LANES-1:0] lanes,
	input  wire                                                edge_column,
	input  wire logic [31:0]                                   row_above,
	output mela_pkg::res_t                                     res
);

	logic tm, cm, bm, moving;

	always_comb begin
		tm = 1'b0;
		cm = 1'b0;
		bm = 1'b0;
		for (int i = 0; i < mela_pkg::NUM_LANES; i++) begin
			tm = tm | lanes[i].tm;
			cm = cm | lanes[i].cm;
			bm = bm | lanes[i].bm;
		end
		moving = cm || (tm && bm);

		res.copied_line = row_above;
		for (int i = 0; i < mela_pkg::NUM_LANES; i++) begin
			// odd lanes carry chroma and are always bobbed
			res.new_line[8*i +: 8] = ((i % 2) == 1 || moving || edge_column) ?
				lanes[i].bob : lanes[i].weave;
		end
	end

endmodule
`default_nettype wire

[hdl/motion_adaptive_ela_deinterlace_core.sv]
// Top level of the motion adaptive ELA deinterlacer: APB registers, four byte
// lanes, lane register stage, merge and output register. Depends on mela_pkg,
// mela_lane, mela_merge and assert_macros.svh.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------
//  pix     | in        | pix_valid/pix_stall | YUYV group plus neighbours
//  res     | out       | res_valid/res_stall | copied and interpolated group
//  apb     | in        | psel/penable/pready | threshold registers
//
// One word per clock while res_stall allows; each word passes the lane register, then the output reg.
// Throughput is set by the four lanes working in parallel on the byte lanes.
// A bubble in either stage is filled even while the output is stalled, so
// pix_stall rises only when both stages hold words and res_stall is high.
// Reset clears the valid flags and loads both thresholds with 15.
`default_nettype none
`include "assert_macros.svh"
module motion_adaptive_ela_deinterlace_core (
	input  wire                              clk,
	input  wire                              arst_n,
	// input words
	input  wire                              pix_valid,
	output logic                             pix_stall,
	input  wire mela_pkg::pix_t              pix,
	// result words
	output logic                             res_valid,
	input  wire                              res_stall,
	output mela_pkg::res_t                   res,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire logic [mela_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	// ---------------- configuration registers ----------------
	logic [7:0] motion_thr_q, vpass_thr_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_thr_q <= mela_pkg::MOTION_THR_RST;
			vpass_thr_q  <= mela_pkg::VPASS_THR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2:2])
				mela_pkg::REG_MOTION_THR: motion_thr_q <= pwdata[7:0];
				mela_pkg::REG_VPASS_THR:  vpass_thr_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			mela_pkg::REG_MOTION_THR: prdata = {24'd0, motion_thr_q};
			mela_pkg::REG_VPASS_THR:  prdata = {24'd0, vpass_thr_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---------------- flow control ----------------
	logic vld_s1, adv_out, adv_s1, pix_acc;

	assign adv_out   = !res_valid || !res_stall;
	assign adv_s1    = !vld_s1 || adv_out;
	assign pix_stall = !adv_s1;
	assign pix_acc   = pix_valid && adv_s1;

	// ---------------- neighbourhood build ----------------
	// shifted groups line up like components: a/c two bytes left/right on the
	// upper line, d/f likewise on the lower line
	logic [31:0] grp_a, grp_c, grp_d, grp_f;

	assign grp_a = {pix.row_above[15:0], pix.above_left};
	assign grp_c = {pix.above_right, pix.row_above[31:16]};
	assign grp_d = {pix.row_below[15:0], pix.below_left};
	assign grp_f = {pix.below_right, pix.row_below[31:16]};

	mela_pkg::lane_in_t  lane_in  [mela_pkg::NUM_LANES];
	mela_pkg::lane_out_t [mela_pkg::NUM_LANES-1:0] lane_out;

	for (genvar g = 0; g < mela_pkg::NUM_LANES; g++) begin : g_lane
		assign lane_in[g].va  = grp_a[8*g +: 8];
		assign lane_in[g].vb  = pix.row_above[8*g +: 8];
		assign lane_in[g].vc  = grp_c[8*g +: 8];
		assign lane_in[g].vd  = grp_d[8*g +: 8];
		assign lane_in[g].ve  = pix.row_below[8*g +: 8];
		assign lane_in[g].vf  = grp_f[8*g +: 8];
		assign lane_in[g].prv = pix.prev_opposite[8*g +: 8];
		assign lane_in[g].nxt = pix.next_opposite[8*g +: 8];
		assign lane_in[g].psa = pix.prev_same_above[8*g +: 8];
		assign lane_in[g].psb = pix.prev_same_below[8*g +: 8];

		mela_lane u_lane (
			.din         (lane_in[g]),
			.chroma      ((g % 2) == 1),
			.edge_column (pix.edge_column),
			.motion_thr  (motion_thr_q),
			.vpass_thr   (vpass_thr_q),
			.dout        (lane_out[g])
		);
	end

	// ---------------- lane register stage ----------------
	mela_pkg::lane_out_t [mela_pkg::NUM_LANES-1:0] lanes_s1;
	logic        edge_s1;
	logic [31:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			lanes_s1 <= lane_out;
			edge_s1  <= pix.edge_column;
			row_s1   <= pix.row_above;
		end
	end

	// ---------------- merge and output register ----------------
	mela_pkg::res_t merged;

	mela_merge u_merge (
		.lanes       (lanes_s1),
		.edge_column (edge_s1),
		.row_above   (row_s1),
		.res         (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv_out) begin
			res_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && vld_s1) begin
			res <= merged;
		end
	end

	// ---------------- assertions ----------------
	`MELA_ASSERT(a_stall_only_full, clk, arst_n, pix_stall |-> (vld_s1 && res_valid && res_stall))
	`MELA_ASSERT(a_acc_reaches_s1, clk, arst_n, pix_acc |=> vld_s1)
	`MELA_ASSERT(a_copy_path, clk, arst_n, (vld_s1 && adv_out) |=> (res_valid && res.copied_line == $past(row_s1)))
	`MELA_ASSERT_ALWAYS(a_pready_high, clk, pready)

endmodule
`default_nettype wire
